// ===== rtl/lett_pkg.sv =====
// Package for the lamp edge tempo tracker: defaults, register indexes and sequencer states.
`default_nettype none
package lett_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_HISTORY       = 5;
    localparam int DEF_FRACTION_BITS = 10;
    localparam int DEF_TIME_BITS     = 40;

    // Integer tempo bits in front of the fraction.
    localparam int TEMPO_INT_BITS = 9;

    // Microseconds in one minute, and the tempo held after reset in BPM.
    localparam int US_PER_MINUTE   = 60000000;
    localparam int RESET_TEMPO_BPM = 120;

    // The change threshold is scaled by this many bits (1/1024 units).
    localparam int TOL_SHIFT = 10;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CEILING   = 2'd2;

    localparam logic [9:0] RST_TOLERANCE = 10'd51;
    localparam logic [7:0] RST_FLOOR     = 8'd80;
    localparam logic [8:0] RST_CEILING   = 9'd400;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQREF,
        ST_INTV,
        ST_DIVW,
        ST_F1,
        ST_F2M,
        ST_F2C,
        ST_F3M,
        ST_F3C,
        ST_AVG,
        ST_CMP,
        ST_CMPC,
        ST_BH,
        ST_BL
    } lett_state_t;

endpackage
`default_nettype wire

// ===== rtl/lamp_edge_tempo_tracker.sv =====
// Top level of the lamp edge tempo tracker: edge history, sequencer and shared multiplier.
`default_nettype none
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_valid / s_ready     lamp bytes 1..3, time_us
//  m_        out        m_valid / m_ready     tempo_q10, tempo_changed, change_time_us,
//                                             warming_up
//  cfg_      in         cfg_wr_en, no wait    cfg_index, cfg_wr_data
//
// A beat with no rising lamp edge, or one taken during warm-up, is answered in the cycle
// after it is accepted. A beat that triggers an estimate, for each interval, issues a
// division to the serial divider and then folds the quotient: coarse halvings, then fine
// halvings and doublings, each of which is a multiply and a compare. The average takes one
// more division and fold, and then the compare; a change of tempo adds the fold into the
// floor and ceiling band.
// Reset is synchronous and active low; it restores the default registers, clears the
// history and sets the tempo to 120 BPM. While an item is in flight, or while a result
// beat waits for m_ready, s_ready stays low.
//
module lamp_edge_tempo_tracker
    import lett_pkg::*;
#(
    parameter int HISTORY       = DEF_HISTORY,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int TIME_BITS     = DEF_TIME_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_lamp_byte1,
    input  wire logic [7:0]                          s_lamp_byte2,
    input  wire logic [7:0]                          s_lamp_byte3,
    input  wire logic [TIME_BITS-1:0]                s_time_us,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [TEMPO_INT_BITS+FRACTION_BITS-1:0]  m_tempo_q10,
    output logic                                     m_tempo_changed,
    output logic [TIME_BITS-1:0]                     m_change_time_us,
    output logic                                     m_warming_up,
    input  wire logic                                cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               cfg_wr_data
);

    // Tempo width, multiplier operand width, and the width of the interval numerator.
    localparam int TW   = TEMPO_INT_BITS + FRACTION_BITS;
    localparam int MW   = TW + 2;
    localparam int NUMW = ((26 + FRACTION_BITS > TIME_BITS) ? 26 + FRACTION_BITS
                                                            : TIME_BITS) + 1;
    localparam int VW   = NUMW;
    localparam int CW   = $clog2(HISTORY);
    localparam int EW   = $clog2(HISTORY + 1);
    localparam int SW   = MW + CW;
    localparam int PW   = 2 * MW;
    localparam int XW   = VW + TOL_SHIFT + PW;

    localparam logic [NUMW-1:0] NUM_BASE  = NUMW'(US_PER_MINUTE) << FRACTION_BITS;
    localparam logic [TW-1:0]   TEMPO_RST = TW'(RESET_TEMPO_BPM) << FRACTION_BITS;

    lett_state_t state_reg, state_next;

    // Configuration registers.
    logic [9:0] tol_reg, tol_next;
    logic [7:0] floor_reg, floor_next;
    logic [8:0] ceil_reg, ceil_next;

    // Architectural state.
    logic [4:0]           prev_reg, prev_next;
    logic [TIME_BITS-1:0] hist_reg [HISTORY];
    logic [TIME_BITS-1:0] hist_next [HISTORY];
    logic [EW-1:0]        seen_reg, seen_next;
    logic [TW-1:0]        cur_reg, cur_next;
    logic [TIME_BITS-1:0] chg_time_reg, chg_time_next;
    logic                 changed_reg, changed_next;
    logic                 m_valid_reg, m_valid_next;

    // Working registers of one estimate.
    logic [TIME_BITS-1:0] work_reg [HISTORY];
    logic [TIME_BITS-1:0] work_next [HISTORY];
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [VW-1:0]        v_reg, v_next;
    logic                 avg_mode_reg, avg_mode_next;
    logic [PW-1:0]        rr_reg, rr_next;
    logic [PW-1:0]        sq_reg, sq_next;

    // Shared multiplier and divider hookup.
    logic [MW-1:0]        mul_a, mul_b;
    logic [PW-1:0]        mul_p;
    logic                 div_start;
    logic [NUMW-1:0]      div_num;
    logic [TIME_BITS-1:0] div_den;
    logic                 div_done;
    logic [NUMW-1:0]      div_quot;

    // Combinational helpers.
    logic                 s_fire;
    logic [4:0]           lamps;
    logic                 rise;
    logic [TIME_BITS-1:0] dt;
    logic [VW-1:0]        v_half;
    logic [VW-1:0]        diff;
    logic [VW-1:0]        band_hi, band_lo;

    lett_div #(
        .NW (NUMW),
        .DW (TIME_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign mul_p = mul_a * mul_b;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;

    // The five watched lamps, in the order the history logic expects.
    assign lamps = {s_lamp_byte1[2], s_lamp_byte3[1], s_lamp_byte3[2],
                    s_lamp_byte3[0], s_lamp_byte2[7]};
    assign rise  = |(lamps & ~prev_reg);

    assign dt      = work_reg[0] - work_reg[1];
    assign v_half  = (v_reg >> 1) + VW'(v_reg[0]);
    assign diff    = (v_reg > VW'(cur_reg)) ? v_reg - VW'(cur_reg) : VW'(cur_reg) - v_reg;
    assign band_hi = VW'((ceil_reg == 9'd0) ? 9'd1 : ceil_reg) << FRACTION_BITS;
    assign band_lo = VW'(floor_reg) << FRACTION_BITS;

    always_comb begin
        state_next    = state_reg;
        tol_next      = tol_reg;
        floor_next    = floor_reg;
        ceil_next     = ceil_reg;
        prev_next     = prev_reg;
        hist_next     = hist_reg;
        seen_next     = seen_reg;
        cur_next      = cur_reg;
        chg_time_next = chg_time_reg;
        changed_next  = changed_reg;
        m_valid_next  = m_valid_reg;
        work_next     = work_reg;
        t_next        = t_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        v_next        = v_reg;
        avg_mode_next = avg_mode_reg;
        rr_next       = rr_reg;
        sq_next       = sq_reg;
        mul_a         = v_reg[MW-1:0];
        mul_b         = v_reg[MW-1:0];
        div_start     = 1'b0;
        div_num       = NUM_BASE + NUMW'(dt >> 1);
        div_den       = dt;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TOLERANCE: tol_next   = cfg_wr_data[9:0];
                REG_FLOOR:     floor_next = cfg_wr_data[7:0];
                REG_CEILING:   ceil_next  = cfg_wr_data[8:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    prev_next    = lamps;
                    t_next       = s_time_us;
                    changed_next = 1'b0;
                    m_valid_next = 1'b1;
                    if (rise) begin
                        hist_next[0] = s_time_us;
                        for (int i = 1; i < HISTORY; i++) begin
                            hist_next[i] = hist_reg[i-1];
                        end
                        if (seen_reg < EW'(HISTORY)) begin
                            seen_next = seen_reg + 1'b1;
                        end else begin
                            // Full history: start an estimate and hold the result back.
                            work_next    = hist_next;
                            m_valid_next = 1'b0;
                            idx_next     = '0;
                            cnt_next     = '0;
                            sum_next     = '0;
                            state_next   = ST_SQREF;
                        end
                    end
                end
            end
            ST_SQREF: begin
                mul_a      = MW'(cur_reg);
                mul_b      = MW'(cur_reg);
                rr_next    = mul_p;
                state_next = ST_INTV;
            end
            ST_INTV: begin
                if (idx_reg == CW'(HISTORY - 1)) begin
                    state_next = ST_AVG;
                end else begin
                    // The newest interval sits at the head; shift it out whether or not a division is issued.
                    for (int i = 0; i < HISTORY - 1; i++) begin
                        work_next[i] = work_reg[i+1];
                    end
                    idx_next = idx_reg + 1'b1;
                    if (dt != '0) begin
                        div_start     = 1'b1;
                        avg_mode_next = 1'b0;
                        state_next    = ST_DIVW;
                    end
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    v_next = div_quot;
                    if (!avg_mode_reg && div_quot == '0) begin
                        state_next = ST_INTV;
                    end else begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_F1: begin
                // Coarse fold: halve until within four times the current tempo.
                if (v_reg > (VW'(cur_reg) << 2)) begin
                    v_next = v_half;
                end else begin
                    state_next = ST_F2M;
                end
            end
            ST_F2M: begin
                sq_next    = mul_p;
                state_next = ST_F2C;
            end
            ST_F2C: begin
                if ({1'b0, sq_reg} >= {rr_reg, 1'b0}) begin
                    v_next     = v_half;
                    state_next = ST_F2M;
                end else begin
                    state_next = ST_F3M;
                end
            end
            ST_F3M: begin
                sq_next    = mul_p;
                state_next = ST_F3C;
            end
            ST_F3C: begin
                if ({sq_reg, 1'b0} <= {1'b0, rr_reg}) begin
                    v_next     = v_reg << 1;
                    state_next = ST_F3M;
                end else if (avg_mode_reg) begin
                    state_next = ST_CMP;
                end else begin
                    sum_next   = sum_reg + SW'(v_reg[MW-1:0]);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_INTV;
                end
            end
            ST_AVG: begin
                if (cnt_reg == '0) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    div_start     = 1'b1;
                    div_num       = NUMW'(sum_reg) + NUMW'(cnt_reg >> 1);
                    div_den       = TIME_BITS'(cnt_reg);
                    avg_mode_next = 1'b1;
                    state_next    = ST_DIVW;
                end
            end
            ST_CMP: begin
                mul_a      = MW'(tol_reg);
                mul_b      = MW'(cur_reg);
                sq_next    = mul_p;
                state_next = ST_CMPC;
            end
            ST_CMPC: begin
                if ((XW'(diff) << TOL_SHIFT) > XW'(sq_reg)) begin
                    state_next = ST_BH;
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BH: begin
                if (v_reg > band_hi) begin
                    v_next = v_half;
                end else begin
                    state_next = ST_BL;
                end
            end
            ST_BL: begin
                if (v_reg != '0 && v_reg < band_lo) begin
                    v_next = v_reg << 1;
                end else begin
                    cur_next      = v_reg[TW-1:0];
                    chg_time_next = t_reg;
                    changed_next  = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= RST_TOLERANCE;
            floor_reg    <= RST_FLOOR;
            ceil_reg     <= RST_CEILING;
            prev_reg     <= '0;
            seen_reg     <= '0;
            cur_reg      <= TEMPO_RST;
            chg_time_reg <= '0;
            changed_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < HISTORY; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            tol_reg      <= tol_next;
            floor_reg    <= floor_next;
            ceil_reg     <= ceil_next;
            prev_reg     <= prev_next;
            seen_reg     <= seen_next;
            cur_reg      <= cur_next;
            chg_time_reg <= chg_time_next;
            changed_reg  <= changed_next;
            m_valid_reg  <= m_valid_next;
            hist_reg     <= hist_next;
        end
        work_reg     <= work_next;
        t_reg        <= t_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        v_reg        <= v_next;
        avg_mode_reg <= avg_mode_next;
        rr_reg       <= rr_next;
        sq_reg       <= sq_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_tempo_q10      = cur_reg;
    assign m_tempo_changed  = changed_reg;
    assign m_change_time_us = chg_time_reg;
    assign m_warming_up     = (seen_reg < EW'(HISTORY));

endmodule
`default_nettype wire

// ===== rtl/lett_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lett_div #(
    parameter int NW = 41,
    parameter int DW = 40
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start) begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNTW'(NW);
            run_next = 1'b1;
        end else if (run_reg) begin
            // Shift in the next numerator bit and try to subtract.
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

// ===== tb/sv/lett_checker.sv =====
// Checker for the lamp edge tempo tracker: watches all three channels, predicts and compares.
module lett_checker
    import lett_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic [7:0]             s_lamp_byte1,
    input  wire logic [7:0]             s_lamp_byte2,
    input  wire logic [7:0]             s_lamp_byte3,
    input  wire logic [39:0]            s_time_us,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [18:0]            m_tempo_q10,
    input  wire logic                   m_tempo_changed,
    input  wire logic [39:0]            m_change_time_us,
    input  wire logic                   m_warming_up,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [18:0] tempo;
        logic        changed;
        logic [39:0] change_time;
        logic        warming;
    } tempo_report_t;

    localparam int NHIST = DEF_HISTORY;
    localparam int FRAC  = DEF_FRACTION_BITS;

    tempo_report_t      report_q[$];
    logic [9:0]         tol_reg;
    logic [7:0]         floor_reg;
    logic [8:0]         ceil_reg;
    logic [4:0]         prev_lamps;
    logic [39:0]        beat_times[NHIST];
    int unsigned        beats_seen;
    logic [18:0]        tempo_now;
    logic [39:0]        last_change;

    // Octave fold toward a reference tempo; halving rounds half up.
    function automatic longint unsigned fold_octave(longint unsigned v, longint unsigned r);
        while (v > 4 * r) v = (v >> 1) + (v & 1);
        while (v * v >= 2 * r * r) v = (v >> 1) + (v & 1);
        while (2 * v * v <= r * r) v = v << 1;
        return v;
    endfunction

    function automatic longint unsigned fold_into_band(longint unsigned v);
        longint unsigned hi;
        longint unsigned lo;
        hi = longint'((ceil_reg == 0) ? 1 : ceil_reg) << FRAC;
        lo = longint'(floor_reg) << FRAC;
        while (v > hi) v = (v >> 1) + (v & 1);
        while (v != 0 && v < lo) v = v << 1;
        return v;
    endfunction

    // Advances the tracker state by one sample and returns the expected result beat.
    function automatic tempo_report_t track_sample(logic [7:0] b1, logic [7:0] b2,
                                                   logic [7:0] b3, logic [39:0] t);
        logic [4:0]      lamps;
        logic [39:0]     dt;
        longint unsigned cur, sum, cnt, d, avg, c, diff;
        tempo_report_t   r;
        lamps = {b1[2], b3[1], b3[2], b3[0], b2[7]};
        r.changed = 1'b0;
        if ((lamps & ~prev_lamps) != 0) begin
            for (int i = NHIST - 1; i > 0; i--) beat_times[i] = beat_times[i-1];
            beat_times[0] = t;
            if (beats_seen < NHIST) begin
                beats_seen++;
            end else begin
                cur = tempo_now;
                sum = 0;
                cnt = 0;
                for (int i = 0; i < NHIST - 1; i++) begin
                    dt = beat_times[i] - beat_times[i+1];
                    if (dt != 0) begin
                        d = ((longint'(US_PER_MINUTE) << FRAC) + dt / 2) / dt;
                        if (d != 0) begin
                            sum += fold_octave(d, cur);
                            cnt++;
                        end
                    end
                end
                if (cnt != 0) begin
                    avg = (sum + cnt / 2) / cnt;
                    c = fold_octave(avg, cur);
                    diff = (c > cur) ? c - cur : cur - c;
                    if ((diff << TOL_SHIFT) > tol_reg * cur) begin
                        tempo_now = 19'(fold_into_band(c));
                        last_change = t;
                        r.changed = 1'b1;
                    end
                end
            end
        end
        prev_lamps = lamps;
        r.tempo = tempo_now;
        r.change_time = last_change;
        r.warming = (beats_seen < NHIST);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    assign pending = report_q.size();

    always @(posedge aclk) begin
        tempo_report_t want;
        if (!aresetn) begin
            fail_count = 0;
            report_q.delete();
            tol_reg = RST_TOLERANCE;
            floor_reg = RST_FLOOR;
            ceil_reg = RST_CEILING;
            prev_lamps = '0;
            for (int i = 0; i < NHIST; i++) beat_times[i] = '0;
            beats_seen = 0;
            tempo_now = 19'(RESET_TEMPO_BPM << FRAC);
            last_change = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = report_q.pop_front();
                    if (m_tempo_q10 !== want.tempo)
                        report_mismatch("tempo_q10", m_tempo_q10, want.tempo);
                    if (m_tempo_changed !== want.changed)
                        report_mismatch("tempo_changed", m_tempo_changed, want.changed);
                    if (m_change_time_us !== want.change_time)
                        report_mismatch("change_time_us", m_change_time_us, want.change_time);
                    if (m_warming_up !== want.warming)
                        report_mismatch("warming_up", m_warming_up, want.warming);
                end
            end
            if (s_valid && s_ready)
                report_q.push_back(track_sample(s_lamp_byte1, s_lamp_byte2,
                                                s_lamp_byte3, s_time_us));
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TOLERANCE: tol_reg = cfg_wr_data[9:0];
                    REG_FLOOR:     floor_reg = cfg_wr_data[7:0];
                    REG_CEILING:   ceil_reg = cfg_wr_data[8:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the lamp edge tempo tracker: clock, reset, stimulus and verdict.
module tb_top;
    import lett_pkg::*;

    // With sender gaps, receiver stalls and the one long hold-off, 1800 items are meant to
    // finish well inside this watchdog limit.
    localparam int CYCLE_LIMIT = 4000000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_lamp_byte1 = '0;
    logic [7:0]             s_lamp_byte2 = '0;
    logic [7:0]             s_lamp_byte3 = '0;
    logic [39:0]            s_time_us = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [18:0]            m_tempo_q10;
    logic                   m_tempo_changed;
    logic [39:0]            m_change_time_us;
    logic                   m_warming_up;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    bit          hold_off_request = 1'b0;
    bit          sender_gaps = 1'b1;
    logic [39:0] clock_us;

    lamp_edge_tempo_tracker uut (.*);

    lett_checker checker_i (.*);

    // Two time units per cycle.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lamp_edge_tempo_tracker regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, and stretches with none at all.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The receiver. It drops m_ready for random stretches, and on request it holds off
    // once for a long stretch so that the block fills up and stalls its input.
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request && !held) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                held = 1'b1;
                @(negedge aclk);
            end
            stall = gap_length();
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // One beat on the input channel. Valid stays high into the next item when no gap
    // follows, so back-to-back beats never see valid drop.
    task automatic send_sample(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                               logic [39:0] t);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_lamp_byte1 <= b1;
        s_lamp_byte2 <= b2;
        s_lamp_byte3 <= b3;
        s_time_us <= t;
        do @(posedge aclk); while (!s_ready);
        gap = sender_gaps ? gap_length() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Sends a sample with every watched lamp off, then one that lights the chosen lamp
    // (or all of them when which is 5) at time t. Unwatched bits carry random noise.
    task automatic send_beat(int which, logic [39:0] t);
        logic [7:0] b1, b2, b3;
        b1 = 8'($urandom) & ~8'h04;
        b2 = 8'($urandom) & ~8'h80;
        b3 = 8'($urandom) & ~8'h07;
        send_sample(b1, b2, b3, t - 40'($urandom_range(1, 5000)));
        case (which)
            0: b2 |= 8'h80;
            1: b3 |= 8'h01;
            2: b3 |= 8'h04;
            3: b3 |= 8'h02;
            4: b1 |= 8'h04;
            default: begin
                b1 |= 8'h04;
                b2 |= 8'h80;
                b3 |= 8'h07;
            end
        endcase
        send_sample(b1, b2, b3, t);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Writes all three registers one after another while the block is idle.
    task automatic load_settings(int tol, int flr, int ceil_bpm);
        wait_for_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TOLERANCE;
        cfg_wr_data <= CFG_DATA_W'(tol);
        @(negedge aclk);
        cfg_index <= REG_FLOOR;
        cfg_wr_data <= CFG_DATA_W'(flr);
        @(negedge aclk);
        cfg_index <= REG_CEILING;
        cfg_wr_data <= CFG_DATA_W'(ceil_bpm);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A stretch of random traffic. Most of it is steady beat trains with jitter and
    // the odd tempo jump, octave slip or dropped beat; the rest is raw noise with
    // random bytes and times, zero intervals and intervals of a single microsecond.
    task automatic random_phase(int n_items);
        int          sent;
        int          period;
        int          step;
        int          r;
        sent = 0;
        period = $urandom_range(120000, 1000000);
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                period = $urandom_range(120000, 1000000);
            if (r < 80) begin
                step = period + $urandom_range(0, period / 8) - period / 16;
                if (r < 8) step = step * 2;
                else if (r < 11) step = step / 2;
                clock_us += 40'(step);
                send_beat($urandom_range(0, 5), clock_us);
                sent += 2;
            end else if (r < 85) begin
                send_beat($urandom_range(0, 4), clock_us);
                sent += 2;
            end else if (r < 88) begin
                clock_us += 40'd1;
                send_beat($urandom_range(0, 4), clock_us);
                sent += 2;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    clock_us = {8'($urandom), 32'($urandom)};
                else
                    clock_us += 40'($urandom_range(0, 3000000));
                send_sample(8'($urandom), 8'($urandom), 8'($urandom), clock_us);
                sent += 1;
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings. An all-zero sample, then all lamps
        // rising together (one edge), warm-up on each lamp in turn at 120 BPM, then
        // estimates: double tempo folds back to the same octave, a real change to
        // 150 BPM, a zero interval, a one-microsecond interval and a time wrap.
        sender_gaps = 1'b0;
        send_sample(8'h00, 8'h00, 8'h00, 40'h0);
        send_sample(8'hFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF);
        clock_us = 40'd1000000;
        for (int i = 0; i < 5; i++) begin
            clock_us += 40'd500000;
            send_beat(i, clock_us);
        end
        clock_us += 40'd250000;
        send_beat(0, clock_us);
        clock_us += 40'd400000;
        send_beat(1, clock_us);
        send_beat(2, clock_us);
        clock_us += 40'd1;
        send_beat(3, clock_us);
        clock_us = 40'hFF_FFFF_0000;
        send_beat(4, clock_us);
        clock_us += 40'd400000;
        send_beat(5, clock_us);
        sender_gaps = 1'b1;

        // Random part under several settings, the extremes among them.
        clock_us = {8'($urandom), 32'($urandom)};
        random_phase(300);
        hold_off_request = 1'b1;
        random_phase(50);

        load_settings(0, 1, 511);
        random_phase(250);
        load_settings(1023, 255, 511);
        random_phase(200);
        load_settings(10, 100, 150);
        random_phase(200);
        load_settings(0, 0, 0);
        random_phase(200);
        load_settings($urandom_range(0, 1023), $urandom_range(1, 255),
                      $urandom_range(2, 511));
        random_phase(250);
        load_settings(51, 60, 300);
        random_phase(280);

        wait_for_drain();
        if (fail_count == 0) begin
            $display("lamp_edge_tempo_tracker regression: pass");
        end else begin
            $display("lamp_edge_tempo_tracker regression: fail");
        end
        $finish;
    end

endmodule
